// ----- design/cgm_pkg.sv -----
// Shared types and constants for the colour gradient mapper.
// No dependencies; every design file but cgm_if and cgm_ram uses this package.
`default_nettype none
package cgm_pkg;

	localparam int POS_W     = 16;
	localparam int RGB_W     = 24;
	localparam int LEV_W     = 12;
	localparam int LEN_W     = 17;
	localparam int DIV_NUM_W = 54;
	localparam int DIV_DEN_W = 26;
	localparam int DIV_Q_W   = 28;
	localparam int CH_W      = 28;
	localparam int SUM_W     = 51;
	localparam int NORM_W    = 26;
	localparam int MAG_W     = 26;
	localparam int SQRT_STEPS = 26;

	localparam logic [18:0] MAG_K = 19'd452384;
	localparam logic [DIV_Q_W-1:0] CH_SAT = 28'd16711680;

	typedef enum logic [1:0] {
		CMD_COLOR  = 2'd0,
		CMD_BRIGHT = 2'd1,
		CMD_MAP    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SCAN,
		F_DRAIN,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_LMUL,
		B_LDIV,
		B_LWAIT,
		B_MAG0,
		B_MAG1,
		B_MAG2,
		B_SQ,
		B_SQRT,
		B_CMUL,
		B_CDIV,
		B_CWAIT,
		B_DONE
	} back_state_t;

	// One map job as handed from the front to the back.
	typedef struct packed {
		logic [LEN_W-1:0] passed_c;
		logic [LEN_W-1:0] len_c;
		logic [RGB_W-1:0] rgb_a;
		logic [RGB_W-1:0] rgb_b;
		logic [LEN_W-1:0] passed_b;
		logic [LEN_W-1:0] len_b;
		logic [LEV_W-1:0] lev_a;
		logic [LEV_W-1:0] lev_b;
		logic [15:0]      gain;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

endpackage
`default_nettype wire

// ----- design/cgm_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
// Standalone; field widths are fixed by the block's item format.
`default_nettype none
interface cgm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [3:0]  knot_index;
	logic [15:0] knot_position;
	logic [7:0]  knot_red;
	logic [7:0]  knot_green;
	logic [7:0]  knot_blue;
	logic [11:0] knot_level;
	logic [15:0] level_in;
	logic [15:0] gain;

	modport source(output valid, cmd, knot_index, knot_position, knot_red, knot_green,
		knot_blue, knot_level, level_in, gain, input ready);
	modport sink(input valid, cmd, knot_index, knot_position, knot_red, knot_green,
		knot_blue, knot_level, level_in, gain, output ready);
endinterface

interface cgm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       dark_color;

	modport source(output valid, out_red, out_green, out_blue, dark_color, input ready);
	modport sink(input valid, out_red, out_green, out_blue, dark_color, output ready);
endinterface
`default_nettype wire

// ----- design/cgm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- design/cgm_seg_track.sv -----
// Segment tracker: follows a knot scan and keeps the two knots that bound
// the level, then gives passed and length. Uses cgm_pkg.
`default_nettype none
module cgm_seg_track #(
	parameter int AW = 4,
	parameter int PW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clear,
	input  logic                   rv,
	input  logic [AW-1:0]          rj,
	input  logic [15:0]            rpos,
	input  logic [PW-1:0]          rpay,
	input  logic [15:0]            v,
	input  logic [AW-1:0]          segs,
	output logic [cgm_pkg::LEN_W-1:0] passed,
	output logic [cgm_pkg::LEN_W-1:0] len,
	output logic [PW-1:0]          pay_a,
	output logic [PW-1:0]          pay_b
);
	import cgm_pkg::*;

	logic [AW-1:0]    k_q;
	logic [15:0]      a_pos_q, b_pos_q;
	logic [PW-1:0]    a_pay_q, b_pay_q;
	logic             hit;
	logic [LEN_W-1:0] seg_start, seg_end, diff;

	assign hit = (rj != '0) && (rj < segs) && (rpos <= v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (clear) begin
			k_q <= '0;
		end else if (rv && hit) begin
			k_q <= rj;
		end
	end

	// b is taken against the old k, so a later hit moves it on
	always_ff @(posedge clk) begin
		if (rv) begin
			if (rj == k_q + AW'(1)) begin
				b_pos_q <= rpos;
				b_pay_q <= rpay;
			end
			if (rj == '0 || hit) begin
				a_pos_q <= rpos;
				a_pay_q <= rpay;
			end
		end
	end

	always_comb begin
		seg_start = (k_q == '0) ? '0 : {1'b0, a_pos_q};
		seg_end   = (k_q == segs - AW'(1)) ? 17'h10000 : {1'b0, b_pos_q};
		len       = (seg_end > seg_start) ? seg_end - seg_start : '0;
		diff      = {1'b0, v} - seg_start;
		passed    = (diff > len) ? len : diff;
	end

	assign pay_a = a_pay_q;
	assign pay_b = b_pay_q;
endmodule
`default_nettype wire

// ----- design/cgm_front.sv -----
// Front end: takes input beats, writes knots, scans the knot RAMs for a map
// item and queues the job. Uses cgm_pkg, cgm_if, cgm_ram, cgm_seg_track.
`default_nettype none
module cgm_front #(
	parameter int MAX_SEGMENTS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	cgm_in_if.sink        in_ch,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [3:0]    cfg_data,
	output cgm_pkg::qctl_t qctl_push,
	input  logic          q_full,
	output cgm_pkg::job_t job
);
	import cgm_pkg::*;

	localparam int NK = MAX_SEGMENTS + 1;
	localparam int AW = $clog2(NK);

	front_state_t state_q, state_d;
	logic [3:0]    color_segs_q, bright_segs_q;
	logic [AW-1:0] sc, sb, smax, j_q, rj_s1;
	logic          rv_s1;
	logic [15:0]   v_q, gain_q;
	logic          accept, wr_ok, is_map, clear;
	logic [39:0]   c_rd;
	logic [27:0]   b_rd;
	logic          push;
	logic [LEN_W-1:0] passed_c, len_c, passed_b, len_b;
	logic [RGB_W-1:0] rgb_a, rgb_b;
	logic [LEV_W-1:0] lev_a, lev_b;

	function automatic logic [AW-1:0] clamp_segs(input logic [3:0] s);
		if (s == 4'd0) return AW'(1);
		if (int'(s) > MAX_SEGMENTS) return AW'(MAX_SEGMENTS);
		return AW'(s);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_segs_q  <= 4'd1;
			bright_segs_q <= 4'd1;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) color_segs_q <= cfg_data;
			else bright_segs_q <= cfg_data;
		end
	end

	assign sc     = clamp_segs(color_segs_q);
	assign sb     = clamp_segs(bright_segs_q);
	assign smax   = (sc > sb) ? sc : sb;
	assign accept = in_ch.valid && in_ch.ready;
	assign wr_ok  = int'(in_ch.knot_index) <= MAX_SEGMENTS;
	assign is_map = cmd_t'(in_ch.cmd) == CMD_MAP;
	assign clear  = accept && is_map;

	cgm_ram #(.WIDTH(40), .DEPTH(NK)) u_cram (
		.clk  (clk),
		.we   (accept && wr_ok && cmd_t'(in_ch.cmd) == CMD_COLOR),
		.waddr(AW'(in_ch.knot_index)),
		.wdata({in_ch.knot_position, in_ch.knot_red, in_ch.knot_green, in_ch.knot_blue}),
		.raddr(j_q),
		.rdata(c_rd)
	);

	cgm_ram #(.WIDTH(28), .DEPTH(NK)) u_bram (
		.clk  (clk),
		.we   (accept && wr_ok && cmd_t'(in_ch.cmd) == CMD_BRIGHT),
		.waddr(AW'(in_ch.knot_index)),
		.wdata({in_ch.knot_position, in_ch.knot_level}),
		.raddr(j_q),
		.rdata(b_rd)
	);

	cgm_seg_track #(.AW(AW), .PW(RGB_W)) u_ctrack (
		.clk(clk), .arst_n(arst_n), .clear(clear), .rv(rv_s1), .rj(rj_s1),
		.rpos(c_rd[39:24]), .rpay(c_rd[23:0]), .v(v_q), .segs(sc),
		.passed(passed_c), .len(len_c), .pay_a(rgb_a), .pay_b(rgb_b)
	);

	cgm_seg_track #(.AW(AW), .PW(LEV_W)) u_btrack (
		.clk(clk), .arst_n(arst_n), .clear(clear), .rv(rv_s1), .rj(rj_s1),
		.rpos(b_rd[27:12]), .rpay(b_rd[11:0]), .v(v_q), .segs(sb),
		.passed(passed_b), .len(len_b), .pay_a(lev_a), .pay_b(lev_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= (state_q == F_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		rj_s1 <= j_q;
		if (clear) begin
			v_q    <= in_ch.level_in;
			gain_q <= in_ch.gain;
			j_q    <= '0;
		end else if (state_q == F_SCAN) begin
			j_q <= j_q + AW'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE:  if (clear) state_d = F_SCAN;
			F_SCAN:  if (j_q == smax) state_d = F_DRAIN;
			F_DRAIN: state_d = F_PUSH;
			F_PUSH:  if (!q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		push        = 1'b0;
		case (state_q)
			F_IDLE:  in_ch.ready = 1'b1;
			F_PUSH:  push = !q_full;
			default: ;
		endcase
	end

	assign qctl_push.push = push;
	assign qctl_push.full = q_full;

	always_comb begin
		job.passed_c = passed_c;
		job.len_c    = len_c;
		job.rgb_a    = rgb_a;
		job.rgb_b    = rgb_b;
		job.passed_b = passed_b;
		job.len_b    = len_b;
		job.lev_a    = lev_a;
		job.lev_b    = lev_b;
		job.gain     = gain_q;
	end
endmodule
`default_nettype wire

// ----- design/cgm_queue.sv -----
// Two-entry job queue between the front end and the back end.
// Uses cgm_pkg.
`default_nettype none
module cgm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  cgm_pkg::qctl_t qctl_push,
	input  cgm_pkg::job_t  wr_job,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output cgm_pkg::job_t  rd_job
);
	import cgm_pkg::*;

	job_t       e_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign push  = qctl_push.push;
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rd_job = e_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) e_q[wp_q] <= wr_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("job popped from an empty queue");
endmodule
`default_nettype wire

// ----- design/cgm_div.sv -----
// Restoring divider, one quotient bit a cycle, 28 quotient bits.
// Caller guarantees the quotient fits. Uses cgm_pkg.
`default_nettype none
module cgm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cgm_pkg::DIV_NUM_W-1:0] num,
	input  logic [cgm_pkg::DIV_DEN_W-1:0] den,
	output logic                         busy,
	output logic [cgm_pkg::DIV_Q_W-1:0]   quo
);
	import cgm_pkg::*;

	logic                 busy_q;
	logic [4:0]           cnt_q;
	logic [DIV_DEN_W-1:0] rem_q, den_q;
	logic [DIV_Q_W-1:0]   low_q;
	logic [DIV_DEN_W:0]   t, td;
	logic                 ge;

	assign t  = {rem_q, low_q[DIV_Q_W-1]};
	assign ge = t >= {1'b0, den_q};
	assign td = t - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(DIV_Q_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DIV_NUM_W-1:DIV_Q_W];
			low_q <= num[DIV_Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? td[DIV_DEN_W-1:0] : t[DIV_DEN_W-1:0];
			low_q <= {low_q[DIV_Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = low_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
endmodule
`default_nettype wire

// ----- design/cgm_back.sv -----
// Back end: interpolates, forms the magnitude, takes the colour length and
// rescales the channels. Uses cgm_pkg, cgm_if, cgm_div.
`default_nettype none
module cgm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cgm_pkg::job_t job,
	input  logic          job_valid,
	output logic          pop,
	cgm_out_if.source     out_ch
);
	import cgm_pkg::*;

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [1:0]  l_q;
	logic [28:0] prod_q;
	logic [CH_W-1:0] ch_q [4];
	logic [43:0] p44_q;
	logic [41:0] acc_q;
	logic [MAG_W-1:0] mag_q;
	logic [SUM_W-1:0] x_q, r_q, bit_q;
	logic [4:0]  cnt_q;
	logic [49:0] prod2_q;
	logic [7:0]  chan_q [3];
	logic        dark_q;
	logic        out_valid_q;
	logic [7:0]  out_r_q, out_g_q, out_b_q;
	logic        out_dark_q;

	logic [LEV_W-1:0] a_sel, b_sel, d_sel;
	logic [LEN_W-1:0] passed_sel, len_sel;
	logic             up;
	logic [CH_W-1:0]  base;
	logic [23:0]      ch24;
	logic [SUM_W-1:0] rb;
	logic [63:0]      mag_sum;
	logic             div_start, div_busy, out_load;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_Q_W-1:0]   div_q;
	logic [7:0]           sat;

	always_comb begin
		case (l_q)
			2'd0: begin
				a_sel = {4'd0, job_q.rgb_a[23:16]};
				b_sel = {4'd0, job_q.rgb_b[23:16]};
			end
			2'd1: begin
				a_sel = {4'd0, job_q.rgb_a[15:8]};
				b_sel = {4'd0, job_q.rgb_b[15:8]};
			end
			2'd2: begin
				a_sel = {4'd0, job_q.rgb_a[7:0]};
				b_sel = {4'd0, job_q.rgb_b[7:0]};
			end
			default: begin
				a_sel = job_q.lev_a;
				b_sel = job_q.lev_b;
			end
		endcase
		passed_sel = (l_q == 2'd3) ? job_q.passed_b : job_q.passed_c;
		len_sel    = (l_q == 2'd3) ? job_q.len_b : job_q.len_c;
		up         = b_sel >= a_sel;
		d_sel      = up ? b_sel - a_sel : a_sel - b_sel;
		base       = {a_sel, 16'd0};
		ch24       = ch_q[l_q][23:0];
		rb         = r_q + bit_q;
		mag_sum    = 64'(acc_q) + ((64'(p44_q[43:22]) * 64'(MAG_K)) << 22);
		sat        = (div_q >= CH_SAT) ? 8'd255 : 8'((div_q + 28'd32768) >> 16);
	end

	always_comb begin
		div_num = '0;
		div_den = '0;
		if (state_q == B_LDIV) begin
			div_num = DIV_NUM_W'({prod_q, 16'd0}) + DIV_NUM_W'(len_sel >> 1);
			div_den = DIV_DEN_W'(len_sel);
		end else begin
			div_num = DIV_NUM_W'(prod2_q);
			div_den = r_q[NORM_W-1:0];
		end
	end

	cgm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .quo(div_q)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (job_valid) state_d = B_LMUL;
			B_LMUL: begin
				if (len_sel != '0) state_d = B_LDIV;
				else if (l_q == 2'd3) state_d = B_MAG0;
			end
			B_LDIV:  state_d = B_LWAIT;
			B_LWAIT: if (!div_busy) state_d = (l_q == 2'd3) ? B_MAG0 : B_LMUL;
			B_MAG0:  state_d = B_MAG1;
			B_MAG1:  state_d = B_MAG2;
			B_MAG2:  state_d = B_SQ;
			B_SQ:    if (l_q == 2'd2) state_d = B_SQRT;
			B_SQRT: begin
				if (cnt_q == '0) state_d = (r_q == '0) ? B_DONE : B_CMUL;
			end
			B_CMUL:  state_d = B_CDIV;
			B_CDIV:  state_d = B_CWAIT;
			B_CWAIT: if (!div_busy) state_d = (l_q == 2'd2) ? B_DONE : B_CMUL;
			B_DONE:  if (!out_valid_q || out_ch.ready) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			B_IDLE:  pop = job_valid;
			B_LDIV:  div_start = 1'b1;
			B_CDIV:  div_start = 1'b1;
			B_DONE:  out_load = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_q  <= job;
					l_q    <= 2'd0;
					dark_q <= 1'b0;
				end
			end
			B_LMUL: begin
				prod_q <= d_sel * passed_sel;
				if (len_sel == '0) begin
					ch_q[l_q] <= base;
					l_q       <= l_q + 2'd1;
				end
			end
			B_LWAIT: begin
				if (!div_busy) begin
					ch_q[l_q] <= up ? base + div_q : base - div_q;
					l_q       <= l_q + 2'd1;
				end
			end
			B_MAG0: p44_q <= ch_q[3] * job_q.gain;
			B_MAG1: acc_q <= 42'(p44_q[21:0]) * 42'(MAG_K) + 42'h10_0000_0000;
			B_MAG2: begin
				mag_q <= mag_sum[37+MAG_W-1:37];
				l_q   <= 2'd0;
				x_q   <= '0;
				r_q   <= '0;
				bit_q <= SUM_W'(1) << (SUM_W - 1);
				cnt_q <= 5'(SQRT_STEPS);
			end
			B_SQ: begin
				x_q <= x_q + SUM_W'(ch24) * SUM_W'(ch24);
				l_q <= l_q + 2'd1;
			end
			B_SQRT: begin
				if (cnt_q != '0) begin
					if (x_q >= rb) begin
						x_q <= x_q - rb;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q - 5'd1;
				end else begin
					l_q    <= 2'd0;
					dark_q <= (r_q == '0);
				end
			end
			B_CMUL: prod2_q <= ch24 * mag_q;
			B_CWAIT: begin
				if (!div_busy) begin
					chan_q[l_q] <= sat;
					l_q         <= l_q + 2'd1;
				end
			end
			B_DONE: begin
				if (out_load) begin
					out_r_q    <= dark_q ? 8'd0 : chan_q[0];
					out_g_q    <= dark_q ? 8'd0 : chan_q[1];
					out_b_q    <= dark_q ? 8'd0 : chan_q[2];
					out_dark_q <= dark_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_red    = out_r_q;
	assign out_ch.out_green  = out_g_q;
	assign out_ch.out_blue   = out_b_q;
	assign out_ch.dark_color = out_dark_q;

	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CDIV) |-> (r_q != '0)) else $error("channel divide by zero length");
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == B_IDLE && job_valid)) else $error("job popped while busy");
endmodule
`default_nettype wire

// ----- design/color_gradient_mapper_core.sv -----
// Colour gradient mapper: knot writes (cmd 0/1) are taken by the front
// end and give no result. A map item (cmd 2) first scans the knot RAMs, one
// knot a cycle, then waits in a two-entry queue for the back end, which
// works through up to four 28-step divisions for the interpolation, a
// 26-step square root for the colour length and up to three more 28-step
// divisions for the rescale, all through one shared divider. A new map item
// can be scanned while the back end works on the last; the front end keeps
// taking knot writes too, unless a scanned item waits on a full queue.
// Results sit in an output register until taken.
`default_nettype none
module color_gradient_mapper_core #(
	parameter int MAX_SEGMENTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	cgm_in_if.sink     in_ch,
	cgm_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data
);
	import cgm_pkg::*;

	qctl_t qctl;
	job_t  wr_job, rd_job;
	logic  q_full, q_empty, pop;

	cgm_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .qctl_push(qctl),
		.q_full(q_full), .job(wr_job)
	);

	cgm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .qctl_push(qctl), .wr_job(wr_job), .pop(pop),
		.full(q_full), .empty(q_empty), .rd_job(rd_job)
	);

	cgm_back u_back (
		.clk(clk), .arst_n(arst_n), .job(rd_job), .job_valid(!q_empty), .pop(pop),
		.out_ch(out_ch)
	);
endmodule
`default_nettype wire
